### hdl/lcdnfw_pkg.sv
package lcdnfw_pkg;

	// Frame geometry and store sizes.
	localparam int LINE_BYTES  = 164;
	localparam int PANEL_COLS  = 640;
	localparam int PANEL_ROWS  = 240;
	localparam int STORE_BYTES = 39524;
	localparam int STORE_COUNT = 2;
	localparam int MEM_DEPTH   = STORE_COUNT * STORE_BYTES;

	// Widths derived from the geometry.
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int POS_W  = $clog2(STORE_BYTES);
	localparam int LINE_W = $clog2(LINE_BYTES);
	localparam int WIDE_W = 20;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] FUNC_PIXEL = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Stream control bits added by a clear.
	localparam logic [7:0] HSYNC_BIT = 8'h10;
	localparam logic [7:0] VSYNC_BIT = 8'h20;
	localparam logic [7:0] CLKEN_BIT = 8'h40;
	localparam logic [7:0] NIBBLE_MASK = 8'h0f;

	// Pixel 0 of a group sits in bit 3. The keep masks also drop the upper nibble.
	localparam logic [7:0] SET_BITS  [4] = '{8'h08, 8'h04, 8'h02, 8'h01};
	localparam logic [7:0] KEEP_MASKS[4] = '{8'h07, 8'h0b, 8'h0d, 8'h0e};

	// Lane swap: stream byte pairs inside a 32-bit word are exchanged.
	localparam logic [WIDE_W-1:0] LANE_SWAP = WIDE_W'(2);

	// First memory address of a store.
	function automatic logic [ADDR_W-1:0] store_base(input logic sel);
		return ADDR_W'(sel) * ADDR_W'(STORE_BYTES);
	endfunction

endpackage

### hdl/lcd_nibble_framebuffer_writer.sv
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tuser: func[1:0]
//                      tdata: col[9:0] row[18:10] turn_on[19] fill_pattern[27:20]
//                             stream_pos[43:28], zero to bit 47
// m_axis    out        tuser: status[0]; tdata: read_byte[7:0]
// cfg       in         data: draw_buffer[0]
//
// A pixel write or a stream read steps through operand capture, address multiply, range
// check with memory read, then modify and write back through the registered-read frame
// memory, and then loads the result register. An out-of-range item skips the write step
// and the unused code skips the check too. A clear walks the selected store one byte per
// cycle and then loads its result. s_axis_tready rises again as the result loads. After
// reset a clearing pass writes zeros through all STORE_COUNT * STORE_BYTES (79048) bytes
// with s_axis_tready low; configuration writes are taken throughout. A new word is taken
// while a result waits on m_axis, and a stalled result holds the block in its final state.
module lcd_nibble_framebuffer_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // col, row, turn_on, fill_pattern, stream_pos
	input  logic [1:0]  s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // read_byte
	output logic        m_axis_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data       // draw_buffer
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_MOD   = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	localparam int AW = lcdnfw_pkg::ADDR_W;
	localparam int PW = lcdnfw_pkg::POS_W;
	localparam int LW = lcdnfw_pkg::LINE_W;
	localparam int WW = lcdnfw_pkg::WIDE_W;

	logic [2:0]    state_q;
	logic          draw_q;
	logic [AW-1:0] init_q;

	// Captured operands.
	logic [1:0]    func_q;
	logic [9:0]    col_q;
	logic [8:0]    row_q;
	logic          on_q;
	logic [7:0]    pat_q;
	logic [15:0]   spos_q;

	// Working registers of one item.
	logic [WW-1:0] pos_q;
	logic          bad_q;
	logic [AW-1:0] addr_q;
	logic          res_status_q;
	logic [7:0]    res_byte_q;

	// Clear walker and its pipeline stage.
	logic [PW-1:0] cpos_q;
	logic [LW-1:0] line_q;
	logic          we_s1;
	logic [AW-1:0] addr_s1;
	logic          hs_s1;
	logic          vs_s1;
	logic          ck_s1;

	// Result register.
	logic          out_valid_q;
	logic          out_status_q;
	logic [7:0]    out_byte_q;

	// Frame memory.
	logic [7:0]    mem [lcdnfw_pkg::MEM_DEPTH];
	logic [7:0]    rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic [AW-1:0] mem_ra;

	logic          in_take;
	logic          out_free;
	logic [AW-1:0] base;
	logic [WW-1:0] phys_w;
	logic          pos_ok;
	logic [PW-1:0] cphys;
	logic          cskip;
	logic          cvs;
	logic          cck;
	logic          clast;
	logic [7:0]    clr_byte;
	logic [7:0]    pix_byte;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = out_byte_q;

	assign base = lcdnfw_pkg::store_base(draw_q);

	// Range check of the item position and its lane-swapped address.
	assign phys_w = pos_q ^ lcdnfw_pkg::LANE_SWAP;
	assign pos_ok = (pos_q < WW'(lcdnfw_pkg::STORE_BYTES)) &&
		(phys_w < WW'(lcdnfw_pkg::STORE_BYTES));

	// Clear walker decode for the current position.
	assign cphys = cpos_q ^ PW'(2);
	assign cskip = WW'(cphys) >= WW'(lcdnfw_pkg::STORE_BYTES);
	assign cvs   = (WW'(cpos_q) >= WW'(lcdnfw_pkg::LINE_BYTES + 2)) &&
		(WW'(cpos_q) <= WW'(2 * lcdnfw_pkg::LINE_BYTES + 1));
	assign cck   = (WW'(cpos_q) >= WW'(lcdnfw_pkg::LINE_BYTES - 1)) &&
		(line_q >= LW'(3)) && (line_q <= LW'(lcdnfw_pkg::LINE_BYTES - 2));
	assign clast = (cpos_q == PW'(lcdnfw_pkg::STORE_BYTES - 1));

	// Byte written by the clear stage: line starts keep their contents.
	always_comb begin
		clr_byte = hs_s1 ? (rd_q | lcdnfw_pkg::HSYNC_BIT) : (pat_q & lcdnfw_pkg::NIBBLE_MASK);
		if (vs_s1) begin
			clr_byte = clr_byte | lcdnfw_pkg::VSYNC_BIT;
		end
		if (ck_s1) begin
			clr_byte = clr_byte | lcdnfw_pkg::CLKEN_BIT;
		end
	end

	// Pixel read-modify-write value.
	assign pix_byte = on_q ? (rd_q | lcdnfw_pkg::SET_BITS[col_q[1:0]]) :
		(rd_q & lcdnfw_pkg::KEEP_MASKS[col_q[1:0]]);

	// Memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = pix_byte;
		if (state_q == ST_INIT) begin
			mem_we = 1'b1;
			mem_wa = init_q;
			mem_wd = 8'h00;
		end else if (we_s1) begin
			mem_we = 1'b1;
			mem_wa = addr_s1;
			mem_wd = clr_byte;
		end else if (state_q == ST_MOD && func_q == lcdnfw_pkg::FUNC_PIXEL) begin
			mem_we = 1'b1;
		end
		if (state_q == ST_CLEAR) begin
			mem_ra = base + AW'(cphys);
		end else begin
			mem_ra = base + AW'(phys_w);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// Draw buffer register; a store index beyond the store count is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_q <= 1'b0;
		end else if (cfg_valid && cfg_ready && (32'(cfg_data) < 32'(lcdnfw_pkg::STORE_COUNT))) begin
			draw_q <= cfg_data;
		end
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			we_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The clear write follows its read in the next cycle.
			we_s1       <= (state_q == ST_CLEAR) && !cskip;
			// A taken result leaves; a finished item loads the register.
			out_valid_q <= (out_valid_q && !m_axis_tready) || (state_q == ST_DONE && out_free);
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(lcdnfw_pkg::MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (func_q == lcdnfw_pkg::FUNC_CLEAR) begin
						state_q <= ST_CLEAR;
					end else if (func_q == lcdnfw_pkg::FUNC_PIXEL ||
						func_q == lcdnfw_pkg::FUNC_READ) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CHECK: begin
					if (!bad_q && pos_ok) begin
						state_q <= ST_MOD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MOD: begin
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (clast) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand capture, address arithmetic and result payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q       <= s_axis_tuser;
			col_q        <= s_axis_tdata[9:0];
			row_q        <= s_axis_tdata[18:10];
			on_q         <= s_axis_tdata[19];
			pat_q        <= s_axis_tdata[27:20];
			spos_q       <= s_axis_tdata[43:28];
			res_status_q <= 1'b0;
			res_byte_q   <= 8'h00;
		end
		if (state_q == ST_PREP) begin
			cpos_q <= '0;
			line_q <= '0;
			if (func_q == lcdnfw_pkg::FUNC_READ) begin
				pos_q <= WW'(spos_q);
				bad_q <= 1'b0;
			end else begin
				pos_q <= WW'(lcdnfw_pkg::LINE_BYTES) * (WW'(row_q) + WW'(1)) +
					WW'(1) + WW'(col_q[9:2]);
				bad_q <= (32'(col_q) >= 32'(lcdnfw_pkg::PANEL_COLS)) ||
					(32'(row_q) >= 32'(lcdnfw_pkg::PANEL_ROWS));
			end
			if (func_q != lcdnfw_pkg::FUNC_PIXEL && func_q != lcdnfw_pkg::FUNC_CLEAR &&
				func_q != lcdnfw_pkg::FUNC_READ) begin
				res_status_q <= 1'b1;
			end
		end
		if (state_q == ST_CHECK) begin
			addr_q <= mem_ra;
			if (bad_q || !pos_ok) begin
				res_status_q <= 1'b1;
			end
		end
		if (state_q == ST_MOD && func_q == lcdnfw_pkg::FUNC_READ) begin
			res_byte_q <= rd_q;
		end
		// Clear walker: one position per cycle, write in the next cycle.
		if (state_q == ST_CLEAR) begin
			cpos_q  <= cpos_q + PW'(1);
			line_q  <= (line_q == LW'(lcdnfw_pkg::LINE_BYTES - 1)) ? '0 : line_q + LW'(1);
			addr_s1 <= mem_ra;
			hs_s1   <= (line_q == '0);
			vs_s1   <= cvs;
			ck_s1   <= cck;
		end
		if (state_q == ST_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_byte_q   <= res_byte_q;
		end
	end

endmodule
